// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MEI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MEI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mei_pkg.sv =====
package mei_pkg;

	localparam int COORD_BITS_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;
	localparam int CFG_BITS = 16;
	localparam logic [CFG_BITS-1:0] MAX_ITER_RESET = 16'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOP,
		ST_PROD,
		ST_SUM,
		ST_SQX_GO,
		ST_SQX,
		ST_SQY,
		ST_CMP,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic idle;
		logic done;
	} mei_stat_t;

endpackage

// ===== hdl/mandelbrot_escape_iteration.sv =====
// Escape-time iteration for one point c (signed Q4.(COORD_BITS-4)): runs z = z*z + c from
// z = 0 and returns the number of passes kept before |z|^2 exceeds 4, capped at max_iter
// (and at 2^COUNT_BITS-1). All arithmetic is exact except the floor of each new z to the
// coordinate precision. The three products of a pass (zx*zy, then the squares of the new
// zx and zy) all go through one half-width multiplier that takes four partial products
// per product. The block accepts a new point once the previous count has moved to the
// output register. The user is to write max_iter on the configuration channel only
// while idle; the block itself does not enforce this.
`include "assert_macros.svh"

module mandelbrot_escape_iteration #(
	parameter int COORD_BITS = mei_pkg::COORD_BITS_DEF,
	parameter int COUNT_BITS = mei_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  c_real,
	input  logic signed [COORD_BITS-1:0]  c_imag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COUNT_BITS-1:0]         iterations,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mei_pkg::CFG_BITS-1:0]  cfg_data
);

	localparam int LB = (COUNT_BITS > mei_pkg::CFG_BITS) ? COUNT_BITS : mei_pkg::CFG_BITS;

	logic [mei_pkg::CFG_BITS-1:0] max_iter_q;
	logic [LB-1:0]                max_ext, cap;
	logic [COUNT_BITS-1:0]        limit;
	logic                         out_valid_q;
	logic [COUNT_BITS-1:0]        iterations_q;
	logic                         in_take, res_take;
	mei_pkg::mei_stat_t           stat;
	logic [COUNT_BITS-1:0]        count;

	assign max_ext = LB'(max_iter_q);
	assign cap     = LB'({COUNT_BITS{1'b1}});
	assign limit   = (max_ext < cap) ? max_ext[COUNT_BITS-1:0] : cap[COUNT_BITS-1:0];

	assign cfg_ready = 1'b1;
	assign in_ready  = stat.idle;
	assign in_take   = in_valid && in_ready;
	assign res_take  = stat.done && (!out_valid_q || out_ready);

	mei_seq #(
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_take),
		.c_real(c_real),
		.c_imag(c_imag),
		.limit (limit),
		.take  (res_take),
		.stat  (stat),
		.count (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= mei_pkg::MAX_ITER_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_iter_q <= cfg_data;
			if (res_take)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			iterations_q <= count;
	end

	assign out_valid  = out_valid_q;
	assign iterations = iterations_q;

	`MEI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	`MEI_ASSERT_NEXT(a_hold_result, stat.done && out_valid_q && !out_ready, stat.done,
		"finished count dropped while output full")

endmodule

// ===== hdl/mei_mul.sv =====
module mei_mul #(
	parameter int COORD_BITS = mei_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [COORD_BITS-1:0]   a,
	input  logic [COORD_BITS-1:0]   b,
	output logic                    done,
	output logic [2*COORD_BITS-1:0] prod
);

	localparam int W = COORD_BITS;
	localparam int H = (W + 1) / 2;
	localparam int AB = 4 * H;

	logic [2*H-1:0] a_q, b_q;
	logic [AB-1:0]  acc_q;
	logic           run_q;
	logic [1:0]     step_q;
	logic           pv_s1, plast_s1;
	logic [1:0]     step_s1;
	logic [2*H-1:0] pp_s1;
	logic           done_q;

	logic [H-1:0]  a_half, b_half;
	logic [AB-1:0] pp_ext, addend;

	assign a_half = step_q[1] ? a_q[2*H-1:H] : a_q[H-1:0];
	assign b_half = step_q[0] ? b_q[2*H-1:H] : b_q[H-1:0];
	assign pp_ext = {{(AB-2*H){1'b0}}, pp_s1};

	always_comb begin
		case (step_s1)
			2'd0: addend = pp_ext;
			2'd3: addend = pp_ext << (2 * H);
			default: addend = pp_ext << H;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			step_q   <= 2'd0;
			pv_s1    <= 1'b0;
			plast_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 2'd0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3)
					run_q <= 1'b0;
			end
			pv_s1    <= run_q;
			plast_s1 <= run_q && (step_q == 2'd3);
			done_q   <= pv_s1 && plast_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= (2*H)'(a);
			b_q   <= (2*H)'(b);
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + addend;
		end
		if (run_q) begin
			pp_s1   <= a_half * b_half;
			step_s1 <= step_q;
		end
	end

	assign done = done_q;
	assign prod = acc_q[2*W-1:0];

endmodule

// ===== hdl/mei_seq.sv =====
module mei_seq #(
	parameter int COORD_BITS = mei_pkg::COORD_BITS_DEF,
	parameter int COUNT_BITS = mei_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_BITS-1:0]  c_real,
	input  logic signed [COORD_BITS-1:0]  c_imag,
	input  logic [COUNT_BITS-1:0]         limit,
	input  logic                          take,
	output mei_pkg::mei_stat_t            stat,
	output logic [COUNT_BITS-1:0]         count
);

	localparam int W  = COORD_BITS;
	localparam int F  = W - 4;
	localparam int PW = 2 * W;
	localparam int XW = W + 2;
	localparam logic signed [XW-1:0] TWO  = XW'(1) << (F + 1);
	localparam logic signed [XW-1:0] NTWO = -TWO;
	localparam logic [PW:0] THR = (PW+1)'(1) << (2 * F + 2);

	mei_pkg::seq_state_t state_q, state_d;

	logic signed [W-1:0]  cr_q, ci_q, zx_q, zy_q;
	logic [PW-1:0]        sqx_q, sqy_q;
	logic signed [XW-1:0] tx_q, ty_q;
	logic [COUNT_BITS-1:0] cnt_q, limit_q;

	logic                 mul_start, mul_done;
	logic [W-1:0]         mul_a, mul_b;
	logic [PW-1:0]        mul_prod;

	logic [W-1:0]         mag_x, mag_y;
	logic signed [PW:0]   diff, diff_f;
	logic signed [PW+1:0] prod_s, prod_n, twop_f;
	logic signed [XW-1:0] nx, ny;
	logic                 esc_c, esc_r;
	logic [PW:0]          r2;

	mei_mul #(
		.COORD_BITS(COORD_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	assign mag_x = zx_q[W-1] ? W'(-zx_q) : W'(zx_q);
	assign mag_y = zy_q[W-1] ? W'(-zy_q) : W'(zy_q);

	assign diff   = $signed({1'b0, sqx_q}) - $signed({1'b0, sqy_q});
	assign diff_f = diff >>> F;
	assign prod_s = $signed({2'b00, mul_prod});
	assign prod_n = (zx_q[W-1] ^ zy_q[W-1]) ? -prod_s : prod_s;
	assign twop_f = prod_n >>> (F - 1);

	assign nx = tx_q + $signed({{2{cr_q[W-1]}}, cr_q});
	assign ny = ty_q + $signed({{2{ci_q[W-1]}}, ci_q});
	assign esc_c = (nx > TWO) || (nx < NTWO) || (ny > TWO) || (ny < NTWO);

	assign r2 = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign esc_r = r2 > THR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mei_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mei_pkg::ST_IDLE && start)
				cnt_q <= '0;
			else if (state_q == mei_pkg::ST_CMP && !esc_r)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = mag_x;
		mul_b     = mag_y;
		stat      = '0;
		case (state_q)
			mei_pkg::ST_IDLE: begin
				stat.idle = 1'b1;
				if (start)
					state_d = mei_pkg::ST_LOOP;
			end
			mei_pkg::ST_LOOP: begin
				if (cnt_q >= limit_q) begin
					state_d = mei_pkg::ST_DONE;
				end else begin
					mul_start = 1'b1;
					state_d   = mei_pkg::ST_PROD;
				end
			end
			mei_pkg::ST_PROD: begin
				if (mul_done)
					state_d = mei_pkg::ST_SUM;
			end
			mei_pkg::ST_SUM: begin
				state_d = esc_c ? mei_pkg::ST_DONE : mei_pkg::ST_SQX_GO;
			end
			mei_pkg::ST_SQX_GO: begin
				mul_start = 1'b1;
				mul_b     = mag_x;
				state_d   = mei_pkg::ST_SQX;
			end
			mei_pkg::ST_SQX: begin
				mul_a = mag_y;
				if (mul_done) begin
					mul_start = 1'b1;
					state_d   = mei_pkg::ST_SQY;
				end
			end
			mei_pkg::ST_SQY: begin
				if (mul_done)
					state_d = mei_pkg::ST_CMP;
			end
			mei_pkg::ST_CMP: begin
				state_d = esc_r ? mei_pkg::ST_DONE : mei_pkg::ST_LOOP;
			end
			mei_pkg::ST_DONE: begin
				stat.done = 1'b1;
				if (take)
					state_d = mei_pkg::ST_IDLE;
			end
			default: state_d = mei_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mei_pkg::ST_IDLE: begin
				if (start) begin
					cr_q    <= c_real;
					ci_q    <= c_imag;
					limit_q <= limit;
					zx_q    <= '0;
					zy_q    <= '0;
					sqx_q   <= '0;
					sqy_q   <= '0;
				end
			end
			mei_pkg::ST_PROD: begin
				if (mul_done) begin
					tx_q <= diff_f[XW-1:0];
					ty_q <= twop_f[XW-1:0];
				end
			end
			mei_pkg::ST_SUM: begin
				if (!esc_c) begin
					zx_q <= nx[W-1:0];
					zy_q <= ny[W-1:0];
				end
			end
			mei_pkg::ST_SQX: begin
				if (mul_done)
					sqx_q <= mul_prod;
			end
			mei_pkg::ST_SQY: begin
				if (mul_done)
					sqy_q <= mul_prod;
			end
			default: ;
		endcase
	end

	assign count = cnt_q;

endmodule

// ===== test/tb_mandelbrot_escape_iteration.sv =====
module tb_mandelbrot_escape_iteration;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W = mei_pkg::COORD_BITS_DEF;
	localparam int COUNT_W = mei_pkg::COUNT_BITS_DEF;
	localparam int STUCK_LIMIT = 50000;
	localparam int HOLD_CYCLES = 400;
	localparam int SHALLOW_PASSES = 400;
	localparam int PHASES = 8;

	localparam logic signed [COORD_W-1:0] Q_ONE = 64'sh1000_0000_0000_0000;
	localparam logic signed [COORD_W-1:0] Q_TWO = 64'sh2000_0000_0000_0000;
	localparam logic signed [COORD_W-1:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [COORD_W-1:0] Q_MIN = 64'sh8000_0000_0000_0000;

	class escape_scoreboard;
		localparam int FRAC = COORD_W - 4;
		localparam logic signed [131:0] R2_MAX = 132'sd1 <<< (2 * FRAC + 2);

		logic [mei_pkg::CFG_BITS-1:0] max_iter;
		logic [COUNT_W-1:0] counts_due[$];
		int unsigned errors;

		function new();
			max_iter = mei_pkg::MAX_ITER_RESET;
			errors = 0;
		endfunction

		function void set_limit(logic [mei_pkg::CFG_BITS-1:0] v);
			max_iter = v;
		endfunction

		// exact squares and magnitude; only the new z is floored to coordinate precision
		function logic [COUNT_W-1:0] escape_count(logic signed [COORD_W-1:0] cr,
				logic signed [COORD_W-1:0] ci, int unsigned cap);
			logic signed [131:0] zx, zy, nx, ny, r2;
			int unsigned n;
			zx = '0;
			zy = '0;
			n = 0;
			while (n < cap) begin
				nx = ((zx * zx - zy * zy) >>> FRAC) + cr;
				ny = ((zx * zy * 2) >>> FRAC) + ci;
				r2 = nx * nx + ny * ny;
				if (r2 > R2_MAX)
					break;
				zx = nx;
				zy = ny;
				n++;
			end
			return COUNT_W'(n);
		endfunction

		function void note_point(logic signed [COORD_W-1:0] cr, logic signed [COORD_W-1:0] ci);
			counts_due.push_back(escape_count(cr, ci, 32'(max_iter)));
		endfunction

		function void check_count(logic [COUNT_W-1:0] got);
			logic [COUNT_W-1:0] want;
			if (counts_due.size() == 0) begin
				$error("iterations: expected none, got %0d", got);
				errors++;
				return;
			end
			want = counts_due.pop_front();
			if (got !== want) begin
				$error("iterations: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return counts_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [COORD_W-1:0] c_real;
	logic signed [COORD_W-1:0] c_imag;
	logic out_valid;
	logic out_ready;
	logic [COUNT_W-1:0] iterations;
	logic cfg_valid;
	logic cfg_ready;
	logic [mei_pkg::CFG_BITS-1:0] cfg_data;

	escape_scoreboard sb;
	bit tx_quiet;
	bit rx_hold;
	int unsigned stuck_cycles;

	logic [mei_pkg::CFG_BITS-1:0] phase_limit [PHASES] = '{16'd0, 16'd1, 16'd65535, 16'd3,
		16'd20, 16'd256, 16'd100, 16'd7};
	int unsigned phase_items [PHASES] = '{80, 150, 120, 200, 300, 120, 150, 160};

	mandelbrot_escape_iteration u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.c_real(c_real),
		.c_imag(c_imag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.iterations(iterations),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles = stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [COORD_W-1:0] rand_coord();
		logic signed [COORD_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = {$urandom, $urandom};
			1: v = $signed({$urandom, $urandom}) >>> 3;
			2: begin
				case ($urandom_range(0, 5))
					0: v = Q_TWO;
					1: v = -Q_TWO;
					2: v = '0;
					3: v = Q_TWO + 1;
					4: v = -64'sd1;
					default: v = Q_ONE / 4;
				endcase
			end
			default: v = $signed({$urandom, $urandom}) >>> 2;
		endcase
		return v;
	endfunction

	task automatic draw_point(output logic signed [COORD_W-1:0] cr,
			output logic signed [COORD_W-1:0] ci, input bit shallow);
		do begin
			cr = rand_coord();
			ci = rand_coord();
		end while (shallow && sb.escape_count(cr, ci, SHALLOW_PASSES) >= SHALLOW_PASSES);
	endtask

	task automatic send_point(input logic signed [COORD_W-1:0] cr,
			input logic signed [COORD_W-1:0] ci);
		int unsigned gap;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		c_real <= cr;
		c_imag <= ci;
		do @(posedge clk); while (!in_ready);
		sb.note_point(cr, ci);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_iter(input logic [mei_pkg::CFG_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_limit(v);
	endtask

	initial begin
		int unsigned stall;
		bit quiet;
		quiet = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			stall = quiet ? 0 : $urandom_range(0, 13);
			if (rx_hold) begin
				rx_hold = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_count(iterations);
		end
	end

	initial begin
		logic signed [COORD_W-1:0] cr, ci;
		sb = new();
		tx_quiet = 1'b0;
		rx_hold = 1'b0;
		stuck_cycles = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		c_real <= '0;
		c_imag <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit still in force
		send_point('0, '0);
		send_point(Q_MAX, Q_MAX);
		send_point(Q_MIN, Q_MIN);
		send_point(Q_MAX, Q_MIN);
		send_point(-Q_TWO, '0);
		send_point(Q_TWO, '0);
		send_point('0, Q_TWO);
		send_point(Q_TWO + 1, '0);
		send_point(-Q_TWO - 1, '0);
		send_point('0, -Q_TWO - 1);
		send_point(Q_ONE / 4, '0);
		send_point(Q_ONE / 4 + Q_ONE / 100, '0);
		send_point(-Q_ONE, '0);
		send_point('0, Q_ONE);
		send_point('0, -Q_ONE);
		send_point(Q_ONE, Q_ONE);
		send_point(-Q_ONE, -Q_ONE);
		send_point(-(Q_ONE / 4) * 3, Q_ONE / 10);
		send_point(-Q_ONE - Q_ONE / 4, '0);
		send_point(-64'sd1, 64'sd1);

		for (int p = 0; p < PHASES; p++) begin
			wait_drain();
			write_max_iter(phase_limit[p]);
			if (p == 4 || p == 6)
				rx_hold = 1'b1;
			for (int i = 0; i < phase_items[p]; i++) begin
				draw_point(cr, ci, phase_limit[p] > SHALLOW_PASSES);
				send_point(cr, ci);
			end
		end

		wait_drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
